>>> sv/shacc_pkg.sv
package shacc_pkg;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_LOWER_BOUND    = 3'd0;
    localparam logic [2:0] REG_BINS_PER_UNIT  = 3'd1;
    localparam logic [2:0] REG_BIN_COUNT      = 3'd2;
    localparam logic [2:0] REG_CLAMP_OUTLIERS = 3'd3;
    localparam logic [2:0] REG_FOLD_CHANNELS  = 3'd4;
    localparam logic [2:0] REG_FOLD_POSITIONS = 3'd5;
    localparam logic [2:0] REG_WINDOW_START   = 3'd6;
    localparam logic [2:0] REG_WINDOW_END     = 3'd7;

    // Widest counter address the parameter ranges allow (channel, offset, bin).
    localparam int WORK_ADDR_W = 30;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Counter width and limit.
    localparam int COUNT_W = 32;

    // Action codes of an input item.
    typedef enum logic [1:0] {
        OP_ACCUM = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // State of the counter update engine.
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_UPDATE
    } t_back_state;

    // Configuration registers as seen by the classifier.
    typedef struct packed {
        logic signed [31:0] lower_bound;
        logic [31:0]        bins_per_unit;
        logic [6:0]         bin_count;
        logic               clamp_outliers;
        logic               fold_channels;
        logic               fold_positions;
        logic [15:0]        window_start;
        logic [15:0]        window_end;
    } t_cfg;

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic                   hit;
        t_op                    op;
        logic [WORK_ADDR_W-1:0] addr;
        logic [5:0]             bin;
    } t_work;

endpackage

>>> sv/shacc_front.sv
module shacc_front import shacc_pkg::*; #(
    parameter int MAX_CHANNELS  = 16,
    parameter int MAX_POSITIONS = 64,
    parameter int MAX_BINS      = 64,
    parameter int CH_W          = 4,
    parameter int POS_W         = 6,
    parameter int BIN_W         = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_busy,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_channel,
    input  logic [15:0] i_position,
    input  logic [31:0] i_amplitude,
    input  logic [5:0]  i_bin_select,
    output logic        o_push,
    output t_work       o_item,
    input  logic        i_full
);

    logic adv;
    logic accept;

    // Stage A: addressing checks and the magnitude of the offset from the bound.
    logic             r_a_valid;
    t_op              r_a_op;
    logic             r_a_ok;
    logic [CH_W-1:0]  r_a_ch;
    logic [POS_W-1:0] r_a_off;
    logic [5:0]       r_a_sel;
    logic [31:0]      r_a_mag;
    logic             r_a_neg;

    // Stage B: two partial products.
    logic             r_b_valid;
    t_op              r_b_op;
    logic             r_b_ok;
    logic [CH_W-1:0]  r_b_ch;
    logic [POS_W-1:0] r_b_off;
    logic [5:0]       r_b_sel;
    logic             r_b_neg;
    logic [47:0]      r_b_p_hi;
    logic [47:0]      r_b_p_lo;

    // Stage C: full 64-bit product with 32 fractional bits.
    logic             r_c_valid;
    t_op              r_c_op;
    logic             r_c_ok;
    logic [CH_W-1:0]  r_c_ch;
    logic [POS_W-1:0] r_c_off;
    logic [5:0]       r_c_sel;
    logic             r_c_neg;
    logic [63:0]      r_c_prod;

    // Stage D: classified item waiting for a queue slot.
    logic             r_d_valid;
    t_work            r_d_item;

    // Stage A combinational terms.
    logic [3:0]       ch_eff;
    logic             ch_ok;
    logic             win_ok;
    logic [15:0]      acc_off;
    logic             acc_off_ok;
    logic [15:0]      rd_off;
    logic             rd_ok;
    logic             a_ok;
    logic [15:0]      a_off;
    logic [32:0]      diff;
    logic [32:0]      diff_abs;

    // Stage D combinational terms.
    logic [31:0]      ip;
    logic [31:0]      fr;
    logic             round_up;
    logic [32:0]      rounded;
    logic             below;
    logic             above;
    logic [6:0]       nb;
    logic [6:0]       bin7;
    logic             n_hit;
    t_work            n_item;

    // The whole pipeline moves unless the last stage is blocked by a full queue.
    assign adv        = !r_d_valid || !i_full;
    assign o_in_stall = i_busy || !adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_d_valid && !i_full;
    assign o_item     = r_d_item;

    // Window, channel and read address checks, and the signed distance to the bound.
    always_comb begin
        ch_eff     = i_cfg.fold_channels ? 4'd0 : i_channel;
        ch_ok      = 32'(ch_eff) < MAX_CHANNELS;
        win_ok     = (i_position >= i_cfg.window_start) && (i_position < i_cfg.window_end);
        acc_off    = i_position - i_cfg.window_start;
        acc_off_ok = 32'(acc_off) < MAX_POSITIONS;
        rd_off     = i_cfg.fold_positions ? 16'd0 : i_position;
        rd_ok      = (32'(rd_off) < MAX_POSITIONS) && (32'(i_bin_select) < MAX_BINS);
        a_ok       = 1'b0;
        a_off      = rd_off;
        case (t_op'(i_action))
            OP_ACCUM: begin
                a_ok  = ch_ok && win_ok && acc_off_ok;
                a_off = i_cfg.fold_positions ? 16'd0 : acc_off;
            end
            OP_READ:  a_ok = ch_ok && rd_ok;
            OP_CLEAR: a_ok = ch_ok && rd_ok;
            default:  a_ok = 1'b0;
        endcase
        diff     = {i_amplitude[31], i_amplitude} - {i_cfg.lower_bound[31], i_cfg.lower_bound};
        diff_abs = diff[32] ? (33'd0 - diff) : diff;
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_op   <= t_op'(i_action);
            r_a_ok   <= a_ok;
            r_a_ch   <= CH_W'(ch_eff);
            r_a_off  <= POS_W'(a_off);
            r_a_sel  <= i_bin_select;
            r_a_mag  <= diff_abs[31:0];
            r_a_neg  <= diff[32];

            r_b_op   <= r_a_op;
            r_b_ok   <= r_a_ok;
            r_b_ch   <= r_a_ch;
            r_b_off  <= r_a_off;
            r_b_sel  <= r_a_sel;
            r_b_neg  <= r_a_neg;
            r_b_p_hi <= r_a_mag[31:16] * i_cfg.bins_per_unit;
            r_b_p_lo <= r_a_mag[15:0] * i_cfg.bins_per_unit;

            r_c_op   <= r_b_op;
            r_c_ok   <= r_b_ok;
            r_c_ch   <= r_b_ch;
            r_c_off  <= r_b_off;
            r_c_sel  <= r_b_sel;
            r_c_neg  <= r_b_neg;
            r_c_prod <= {r_b_p_hi, 16'd0} + {16'd0, r_b_p_lo};

            r_d_item <= n_item;
        end
    end

    // Round half to even, then place the bin or clamp it to an end bin; reads and clears take the bin select.
    always_comb begin
        ip       = r_c_prod[63:32];
        fr       = r_c_prod[31:0];
        round_up = fr[31] && ((|fr[30:0]) || ip[0]);
        rounded  = {1'b0, ip} + {32'd0, round_up};
        if (i_cfg.bin_count == 7'd0) begin
            nb = 7'd1;
        end else if (32'(i_cfg.bin_count) > MAX_BINS) begin
            nb = 7'(MAX_BINS);
        end else begin
            nb = i_cfg.bin_count;
        end
        below = r_c_neg && (rounded != 33'd0);
        above = !below && (rounded >= {26'd0, nb});
        if (below) begin
            bin7 = 7'd0;
        end else if (above) begin
            bin7 = nb - 7'd1;
        end else begin
            bin7 = rounded[6:0];
        end
        n_hit = r_c_ok;
        if (r_c_op == OP_ACCUM) begin
            n_hit = r_c_ok && (!(below || above) || i_cfg.clamp_outliers);
        end else begin
            bin7 = {1'b0, r_c_sel};
        end
        n_item.hit  = n_hit;
        n_item.op   = r_c_op;
        n_item.addr = WORK_ADDR_W'({r_c_ch, r_c_off, BIN_W'(bin7)});
        n_item.bin  = bin7[5:0];
    end

endmodule

>>> sv/shacc_queue.sv
module shacc_queue import shacc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_work o_head
);

    t_work                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_full  = r_count == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> sv/shacc_back.sv
module shacc_back import shacc_pkg::*; #(
    parameter int ADDR_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_work              i_head,
    output logic               o_pop,
    output logic               o_busy,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [COUNT_W-1:0] o_count,
    output logic [5:0]         o_bin_hit,
    output logic               o_counted,
    output logic               o_saturated
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [COUNT_W-1:0] r_mem [DEPTH];
    logic [COUNT_W-1:0] r_rd_data;

    t_back_state        r_state;
    t_back_state        n_state;
    logic [ADDR_W-1:0]  r_clr_addr;
    t_work              r_job;

    logic               out_free;
    logic               out_load;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    logic [COUNT_W-1:0] mem_wd;
    logic               upd_we;
    logic [COUNT_W-1:0] upd_wd;
    logic [COUNT_W-1:0] res;
    logic [COUNT_W-1:0] bumped;

    logic               r_out_valid;
    logic [COUNT_W-1:0] r_count;
    logic [5:0]         r_bin;
    logic               r_counted;
    logic               r_sat;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_busy      = r_state == BK_CLEAR;
    assign o_out_valid = r_out_valid;
    assign o_count     = r_count;
    assign o_bin_hit   = r_bin;
    assign o_counted   = r_counted;
    assign o_saturated = r_sat;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLEAR:  if (&r_clr_addr) n_state = BK_IDLE;
            BK_IDLE:   if (!i_empty) n_state = BK_UPDATE;
            BK_UPDATE: if (out_free) n_state = BK_IDLE;
            default:   n_state = BK_CLEAR;
        endcase
    end

    // State outputs: queue pop, memory write port and result load.
    always_comb begin
        o_pop    = 1'b0;
        out_load = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = r_job.addr[ADDR_W-1:0];
        mem_wd   = upd_wd;
        unique case (r_state)
            BK_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr_addr;
                mem_wd = '0;
            end
            BK_IDLE:  o_pop = !i_empty;
            BK_UPDATE: begin
                out_load = out_free;
                mem_we   = out_free && upd_we;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // Counter update: saturating increment, plain read, or read and clear.
    always_comb begin
        bumped = (&r_rd_data) ? r_rd_data : r_rd_data + 1'b1;
        res    = r_rd_data;
        upd_wd = '0;
        upd_we = 1'b0;
        case (r_job.op)
            OP_ACCUM: begin
                res    = bumped;
                upd_wd = bumped;
                upd_we = r_job.hit;
            end
            OP_READ:  res = r_rd_data;
            OP_CLEAR: begin
                res    = r_rd_data;
                upd_we = r_job.hit;
            end
            default:  res = '0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Job and result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        if (out_load) begin
            r_count   <= r_job.hit ? res : '0;
            r_bin     <= r_job.hit ? r_job.bin : 6'd0;
            r_counted <= r_job.hit;
            r_sat     <= r_job.hit && (&res);
        end
    end

    // Counter memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    // The counter is read as its item leaves the queue and holds while the result waits.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_mem[i_head.addr[ADDR_W-1:0]];
        end
    end

endmodule

>>> sv/sample_histogram_accumulator.sv
// Amplitude histogram accumulator. Each item is an accumulate, a read, a
// read-and-clear or a no-op action and always yields exactly one result item.
// After reset the counter memory is swept to zero, one entry per cycle, over
// all 2**(CH_W+POS_W+BIN_W) entries (65536 at the default parameters); no item
// is taken during the sweep, while configuration writes are. The front end
// classifies an item in four pipeline stages (bound offset, split multiply,
// product sum, rounding and bin placement) and hands it to a four-entry queue.
// The back end updates one counter at a time through the counter memory's one
// read port and one write port: it reads the counter as the item leaves the
// queue, then writes it back and registers the result, and takes the next item
// only once the result register has taken that result.
module sample_histogram_accumulator import shacc_pkg::*; #(
    parameter int MAX_CHANNELS  = 16,
    parameter int MAX_POSITIONS = 64,
    parameter int MAX_BINS      = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_action,
    input  logic [3:0]            i_channel,
    input  logic [15:0]           i_position,
    input  logic [31:0]           i_amplitude,
    input  logic [5:0]            i_bin_select,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [31:0]           o_count,
    output logic [5:0]            o_bin_hit,
    output logic                  o_counted,
    output logic                  o_saturated
);

    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int POS_W  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int BIN_W  = $clog2(MAX_BINS);
    localparam int ADDR_W = CH_W + POS_W + BIN_W;

    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [2:0] reg_idx;

    logic       busy;
    logic       push;
    t_work      item;
    logic       full;
    logic       pop;
    logic       empty;
    t_work      head;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lower_bound    <= '0;
            r_cfg.bins_per_unit  <= 32'h001E_0000;
            r_cfg.bin_count      <= 7'd30;
            r_cfg.clamp_outliers <= 1'b0;
            r_cfg.fold_channels  <= 1'b0;
            r_cfg.fold_positions <= 1'b0;
            r_cfg.window_start   <= 16'd0;
            r_cfg.window_end     <= 16'hFFFF;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_LOWER_BOUND:    r_cfg.lower_bound    <= pwdata;
                REG_BINS_PER_UNIT:  r_cfg.bins_per_unit  <= pwdata;
                REG_BIN_COUNT:      r_cfg.bin_count      <= pwdata[6:0];
                REG_CLAMP_OUTLIERS: r_cfg.clamp_outliers <= pwdata[0];
                REG_FOLD_CHANNELS:  r_cfg.fold_channels  <= pwdata[0];
                REG_FOLD_POSITIONS: r_cfg.fold_positions <= pwdata[0];
                REG_WINDOW_START:   r_cfg.window_start   <= pwdata[15:0];
                REG_WINDOW_END:     r_cfg.window_end     <= pwdata[15:0];
                default:            r_cfg.window_end     <= r_cfg.window_end;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_idx)
            REG_LOWER_BOUND:    prdata = r_cfg.lower_bound;
            REG_BINS_PER_UNIT:  prdata = r_cfg.bins_per_unit;
            REG_BIN_COUNT:      prdata = {25'd0, r_cfg.bin_count};
            REG_CLAMP_OUTLIERS: prdata = {31'd0, r_cfg.clamp_outliers};
            REG_FOLD_CHANNELS:  prdata = {31'd0, r_cfg.fold_channels};
            REG_FOLD_POSITIONS: prdata = {31'd0, r_cfg.fold_positions};
            REG_WINDOW_START:   prdata = {16'd0, r_cfg.window_start};
            REG_WINDOW_END:     prdata = {16'd0, r_cfg.window_end};
            default:            prdata = '0;
        endcase
    end

    // Classifier pipeline.
    shacc_front #(
        .MAX_CHANNELS  (MAX_CHANNELS),
        .MAX_POSITIONS (MAX_POSITIONS),
        .MAX_BINS      (MAX_BINS),
        .CH_W          (CH_W),
        .POS_W         (POS_W),
        .BIN_W         (BIN_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_busy       (busy),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_channel    (i_channel),
        .i_position   (i_position),
        .i_amplitude  (i_amplitude),
        .i_bin_select (i_bin_select),
        .o_push       (push),
        .o_item       (item),
        .i_full       (full)
    );

    // Queue between classifier and counter engine.
    shacc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    // Counter memory and result register.
    shacc_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_count     (o_count),
        .o_bin_hit   (o_bin_hit),
        .o_counted   (o_counted),
        .o_saturated (o_saturated)
    );

endmodule

>>> tb/sample_histogram_accumulator_checker.sv
`timescale 1ns / 1ps

module sample_histogram_accumulator_checker import shacc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [1:0]            i_action,
    input  logic [3:0]            i_channel,
    input  logic [15:0]           i_position,
    input  logic [31:0]           i_amplitude,
    input  logic [5:0]            i_bin_select,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [31:0]           i_count,
    input  logic [5:0]            i_bin_hit,
    input  logic                  i_counted,
    input  logic                  i_saturated,
    output int                    o_pending,
    output int                    o_fail_count
);

    localparam int HIST_POSITIONS = 64;
    localparam int HIST_BINS      = 64;
    localparam int STORE_DEPTH    = 16 * HIST_POSITIONS * HIST_BINS;
    localparam int REPORT_LIMIT   = 10;
    localparam logic [31:0] COUNT_FULL = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] count;
        logic [5:0]  bin;
        logic        counted;
        logic        saturated;
    } t_bin_result;

    // Own copy of the configuration and of every histogram counter.
    t_cfg        cfg_q;
    logic [31:0] bin_store [0:STORE_DEPTH-1];

    t_bin_result expected_results [$];
    int          outstanding    = 0;
    int          mismatch_total = 0;

    assign o_pending    = outstanding;
    assign o_fail_count = mismatch_total;

    // Applies one item to the counter copy and returns the result it should produce.
    function automatic t_bin_result histogram_step(input t_op act, input logic [3:0] chan,
            input logic [15:0] pos, input logic [31:0] amp, input logic [5:0] sel);
        t_bin_result res;
        logic [3:0]  ch;
        logic [15:0] off;
        logic [6:0]  nbins;
        logic [5:0]  bin;
        logic [32:0] diff;
        logic [32:0] mag;
        logic [63:0] prod;
        logic [32:0] rnd;
        logic        below;
        logic [15:0] idx;
        res = '0;
        // A 4-bit channel always names one of the 16 channels, so none is dropped.
        ch = cfg_q.fold_channels ? 4'd0 : chan;
        if (act == OP_NONE) return res;
        if (act == OP_ACCUM) begin
            if (pos < cfg_q.window_start || pos >= cfg_q.window_end) return res;
            off = pos - cfg_q.window_start;
            if (off >= HIST_POSITIONS) return res;
            if (cfg_q.fold_positions) off = '0;
            // Exact bin: 33-bit difference, full 64-bit product, round half to even.
            diff = {amp[31], amp} - {cfg_q.lower_bound[31], cfg_q.lower_bound};
            mag  = diff[32] ? -diff : diff;
            prod = {32'd0, mag[31:0]} * {32'd0, cfg_q.bins_per_unit};
            rnd  = {1'b0, prod[63:32]};
            if (prod[31:0] > 32'h8000_0000 || (prod[31:0] == 32'h8000_0000 && prod[32]))
                rnd = rnd + 33'd1;
            // A negative value that rounds to zero still lands in the first bin.
            below = diff[32] && (rnd != '0);
            if (cfg_q.bin_count == 7'd0) nbins = 7'd1;
            else if (cfg_q.bin_count > HIST_BINS) nbins = 7'(HIST_BINS);
            else nbins = cfg_q.bin_count;
            if (below) begin
                if (!cfg_q.clamp_outliers) return res;
                bin = 6'd0;
            end else if (rnd >= {26'd0, nbins}) begin
                if (!cfg_q.clamp_outliers) return res;
                bin = 6'(nbins - 7'd1);
            end else begin
                bin = rnd[5:0];
            end
        end else begin
            // Reads ignore the window and the bin count; the select is always in range.
            off = cfg_q.fold_positions ? 16'd0 : pos;
            if (off >= HIST_POSITIONS) return res;
            bin = sel;
        end
        idx = {ch, off[5:0], bin};
        if (act == OP_ACCUM && bin_store[idx] != COUNT_FULL)
            bin_store[idx] = bin_store[idx] + 32'd1;
        res.count     = bin_store[idx];
        res.bin       = bin;
        res.counted   = 1'b1;
        res.saturated = (bin_store[idx] == COUNT_FULL);
        if (act == OP_CLEAR) bin_store[idx] = '0;
        return res;
    endfunction

    // Track configuration writes, check results, then predict the newly accepted item.
    always @(posedge i_clk) begin
        t_bin_result seen;
        t_bin_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < STORE_DEPTH; k++) bin_store[k] = '0;
            cfg_q.lower_bound    = '0;
            cfg_q.bins_per_unit  = 32'd1966080;
            cfg_q.bin_count      = 7'd30;
            cfg_q.clamp_outliers = 1'b0;
            cfg_q.fold_channels  = 1'b0;
            cfg_q.fold_positions = 1'b0;
            cfg_q.window_start   = 16'd0;
            cfg_q.window_end     = 16'hFFFF;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_LOWER_BOUND:    cfg_q.lower_bound    = pwdata;
                    REG_BINS_PER_UNIT:  cfg_q.bins_per_unit  = pwdata;
                    REG_BIN_COUNT:      cfg_q.bin_count      = pwdata[6:0];
                    REG_CLAMP_OUTLIERS: cfg_q.clamp_outliers = pwdata[0];
                    REG_FOLD_CHANNELS:  cfg_q.fold_channels  = pwdata[0];
                    REG_FOLD_POSITIONS: cfg_q.fold_positions = pwdata[0];
                    REG_WINDOW_START:   cfg_q.window_start   = pwdata[15:0];
                    REG_WINDOW_END:     cfg_q.window_end     = pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                seen = {i_count, i_bin_hit, i_counted, i_saturated};
                if (expected_results.size() == 0) begin
                    if (mismatch_total < REPORT_LIMIT)
                        $display("%0t: result item with none expected: count %0d bin %0d",
                                 $realtime, seen.count, seen.bin);
                    mismatch_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (seen.count !== want.count || seen.bin !== want.bin ||
                        seen.counted !== want.counted || seen.saturated !== want.saturated)
                    begin
                        if (mismatch_total < REPORT_LIMIT) begin
                            $display("%0t: mismatch: expected count %0d bin %0d counted %0b saturated %0b",
                                     $realtime, want.count, want.bin, want.counted,
                                     want.saturated);
                            $display("    got count %0d bin %0d counted %0b saturated %0b",
                                     seen.count, seen.bin, seen.counted, seen.saturated);
                        end
                        mismatch_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(histogram_step(t_op'(i_action), i_channel,
                                                          i_position, i_amplitude,
                                                          i_bin_select));
        end
        outstanding = expected_results.size();
    end

endmodule

>>> tb/sample_histogram_accumulator_tb.sv
`timescale 1ns / 1ps

module sample_histogram_accumulator_tb;
    import shacc_pkg::*;

    // No item is taken during the clearing sweep after reset.
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int DRAIN_CYCLES   = 32;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 63;
    localparam int HOLD_CYCLES    = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [1:0]            i_action;
    logic [3:0]            i_channel;
    logic [15:0]           i_position;
    logic [31:0]           i_amplitude;
    logic [5:0]            i_bin_select;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [31:0]           o_count;
    logic [5:0]            o_bin_hit;
    logic                  o_counted;
    logic                  o_saturated;

    int pending;
    int fail_count;
    int tx_gap_max   = 15;
    int rx_gap_max   = 15;
    int rx_hold      = 0;
    int quiet_cycles = 0;

    // Current settings, used to aim samples at real bins and window offsets.
    longint      cur_lb;
    int          cur_w;
    int          cur_nb;
    int          cur_ws;
    logic [3:0]  recent_ch  = '0;
    logic [15:0] recent_off = '0;
    logic [5:0]  recent_bin = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sample_histogram_accumulator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_channel    (i_channel),
        .i_position   (i_position),
        .i_amplitude  (i_amplitude),
        .i_bin_select (i_bin_select),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_count      (o_count),
        .o_bin_hit    (o_bin_hit),
        .o_counted    (o_counted),
        .o_saturated  (o_saturated)
    );

    sample_histogram_accumulator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_channel    (i_channel),
        .i_position   (i_position),
        .i_amplitude  (i_amplitude),
        .i_bin_select (i_bin_select),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_count      (o_count),
        .i_bin_hit    (o_bin_hit),
        .i_counted    (o_counted),
        .i_saturated  (o_saturated),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Ends a hung run: counts cycles in which no item moves on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Result receiver: a random stall before each item, plus one long hold-off in phase 4.
    initial begin
        int wait_len;
        int hold_left;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                hold_left = rx_hold;
                rx_hold   = 0;
                i_out_stall <= 1'b1;
                while (hold_left > 0) begin
                    @(negedge i_clk);
                    hold_left--;
                end
            end
            wait_len = $urandom_range(0, rx_gap_max);
            if (wait_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_len) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // One configuration write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    // Stops offering items and waits until every expected result has arrived.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Writes all registers while the block is idle.
    task automatic program_config(input logic [31:0] lb, input logic [31:0] bpu,
                                  input logic [6:0] nbins, input logic clamp,
                                  input logic fold_ch, input logic fold_pos,
                                  input logic [15:0] ws, input logic [15:0] we,
                                  input int width);
        drain_results();
        apb_write(REG_LOWER_BOUND, lb);
        apb_write(REG_BINS_PER_UNIT, bpu);
        apb_write(REG_BIN_COUNT, 32'(nbins));
        apb_write(REG_CLAMP_OUTLIERS, 32'(clamp));
        apb_write(REG_FOLD_CHANNELS, 32'(fold_ch));
        apb_write(REG_FOLD_POSITIONS, 32'(fold_pos));
        apb_write(REG_WINDOW_START, 32'(ws));
        apb_write(REG_WINDOW_END, 32'(we));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_lb = longint'($signed(lb));
        cur_w  = width;
        cur_ws = int'(ws);
        if (nbins == 7'd0) cur_nb = 1;
        else if (nbins > 7'd64) cur_nb = 64;
        else cur_nb = int'(nbins);
    endtask

    // Offers one item after a random gap and returns once it is accepted.
    task automatic offer(input t_op act, input logic [3:0] ch, input logic [15:0] pos,
                         input logic [31:0] amp, input logic [5:0] sel);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_channel    <= ch;
        i_position   <= pos;
        i_amplitude  <= amp;
        i_bin_select <= sel;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly samples near the window and bins, else reads or clears, often of recent bins.
    task automatic random_item();
        int          roll;
        int          b;
        longint      amp_l;
        logic [15:0] pos;
        logic [5:0]  sel;
        logic [3:0]  ch;
        t_op         act;
        roll = $urandom_range(0, 99);
        ch   = 4'($urandom_range(0, 15));
        b    = 0;
        if (roll < 70) begin
            if ($urandom_range(0, 5) == 0) pos = 16'($urandom);
            else pos = 16'(cur_ws + int'($urandom_range(0, 68)) - 2);
            if ($urandom_range(0, 3) == 0) begin
                amp_l = longint'($urandom);
            end else begin
                b = int'($urandom_range(0, cur_nb + 3)) - 2;
                amp_l = cur_lb + longint'(b) * cur_w + longint'($urandom_range(0, cur_w - 1));
            end
            recent_ch  = ch;
            recent_off = pos - 16'(cur_ws);
            recent_bin = (b < 0) ? 6'd0 : 6'(b);
            offer(OP_ACCUM, ch, pos, 32'(amp_l), 6'($urandom));
        end else if (roll < 97) begin
            if ($urandom_range(0, 1) == 1) begin
                ch  = recent_ch;
                pos = recent_off;
                sel = recent_bin;
            end else begin
                if ($urandom_range(0, 7) == 0) pos = 16'($urandom);
                else pos = 16'($urandom_range(0, 65));
                sel = 6'($urandom);
            end
            if (roll < 85) act = OP_READ;
            else act = OP_CLEAR;
            offer(act, ch, pos, $urandom, sel);
        end else begin
            offer(OP_NONE, ch, 16'($urandom), $urandom, 6'($urandom));
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int p;
        int n;
        int ws_i;
        int we_i;
        int width;
        logic [31:0] lb_v;
        logic [31:0] bpu_v;
        logic [6:0]  nb_v;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_in_valid   = 1'b0;
        i_action     = OP_ACCUM;
        i_channel    = '0;
        i_position   = '0;
        i_amplitude  = '0;
        i_bin_select = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Unit bin width from zero: amplitude k.0 lands in bin k.
        program_config(32'd0, 32'h0001_0000, 7'd8, 1'b0, 1'b0, 1'b0, 16'd0, 16'hFFFF, 65536);
        offer(OP_ACCUM, 4'd0, 16'd0, 32'h0000_0000, 6'd0);
        // Ties round to even: 0.5 to bin 0, 1.5 and 2.5 to bin 2.
        offer(OP_ACCUM, 4'd0, 16'd0, 32'h0000_8000, 6'd0);
        offer(OP_ACCUM, 4'd0, 16'd0, 32'h0001_8000, 6'd0);
        offer(OP_ACCUM, 4'd0, 16'd0, 32'h0002_8000, 6'd0);
        // Small negatives that round to zero still count in bin 0; -1.0 is dropped.
        offer(OP_ACCUM, 4'd0, 16'd0, 32'hFFFF_C000, 6'd0);
        offer(OP_ACCUM, 4'd0, 16'd0, 32'hFFFF_8000, 6'd0);
        offer(OP_ACCUM, 4'd0, 16'd0, 32'hFFFF_0000, 6'd0);
        offer(OP_ACCUM, 4'd0, 16'd0, 32'h7FFF_FFFF, 6'd63);
        offer(OP_ACCUM, 4'd0, 16'd0, 32'h8000_0000, 6'd63);
        offer(OP_ACCUM, 4'd15, 16'd63, 32'h0007_0000, 6'd0);
        offer(OP_ACCUM, 4'd15, 16'd63, 32'h0008_0000, 6'd0);
        // Positions past the tracked width and at the top of the range are ignored.
        offer(OP_ACCUM, 4'd3, 16'd64, 32'h0001_0000, 6'd0);
        offer(OP_ACCUM, 4'd3, 16'hFFFF, 32'h0001_0000, 6'd0);
        offer(OP_NONE, 4'd0, 16'd0, 32'd0, 6'd0);
        offer(OP_READ, 4'd0, 16'd0, 32'd0, 6'd0);
        offer(OP_CLEAR, 4'd0, 16'd0, 32'd0, 6'd0);
        offer(OP_READ, 4'd0, 16'd0, 32'd0, 6'd0);
        offer(OP_READ, 4'd15, 16'd63, 32'd0, 6'd7);
        offer(OP_READ, 4'd15, 16'd64, 32'd0, 6'd7);
        offer(OP_READ, 4'd15, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
        offer(OP_CLEAR, 4'd15, 16'd63, 32'd0, 6'd63);
        // Out-of-range samples go to the end bins once clamping is on.
        program_config(32'd0, 32'h0001_0000, 7'd8, 1'b1, 1'b0, 1'b0, 16'd0, 16'hFFFF, 65536);
        offer(OP_ACCUM, 4'd1, 16'd2, 32'h8000_0000, 6'd0);
        offer(OP_ACCUM, 4'd1, 16'd2, 32'h7FFF_FFFF, 6'd0);
        offer(OP_ACCUM, 4'd1, 16'd2, 32'hFFFF_0000, 6'd0);

        // Random phases, each under its own settings.
        for (p = 0; p < PHASES; p++) begin
            tx_gap_max = (p % 3 == 1) ? 0 : 15;
            rx_gap_max = (p % 4 == 2) ? 0 : 15;
            case (p)
                0: program_config(32'h8000_0000, 32'hFFFF_FFFF, 7'd0, 1'b1, 1'b1, 1'b1,
                                  16'd0, 16'hFFFF, 1);
                1: program_config(32'h7FFF_FFFF, 32'd0, 7'd127, 1'b0, 1'b0, 1'b0,
                                  16'hFFC0, 16'hFFFF, 1);
                // Empty window: accumulates count nothing, reads still work.
                2: program_config($urandom, $urandom, 7'd64, 1'b1, 1'b0, 1'b1,
                                  16'hFFFF, 16'd0, 1);
                default: begin
                    if ($urandom_range(0, 3) == 0) lb_v = $urandom;
                    else lb_v = 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
                    width = int'($urandom_range(2, 32'h3_0000));
                    if ($urandom_range(0, 5) == 0) bpu_v = $urandom;
                    else bpu_v = 32'(64'h1_0000_0000 / longint'(width));
                    if ($urandom_range(0, 4) == 0) nb_v = 7'($urandom_range(0, 127));
                    else nb_v = 7'($urandom_range(1, 64));
                    if ($urandom_range(0, 4) == 0) ws_i = int'($urandom_range(0, 65535));
                    else ws_i = int'($urandom_range(0, 300));
                    if ($urandom_range(0, 5) == 0) we_i = int'($urandom_range(0, 65535));
                    else we_i = ws_i + int'($urandom_range(0, 100));
                    if (we_i > 65535) we_i = 65535;
                    program_config(lb_v, bpu_v, nb_v, 1'($urandom), 1'($urandom),
                                   1'($urandom), 16'(ws_i), 16'(we_i), width);
                end
            endcase
            // Back-pressure: the receiver holds off while items keep coming.
            if (p == 4) begin
                rx_hold    = HOLD_CYCLES;
                tx_gap_max = 0;
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 6 && n == PHASE_ITEMS / 2) drain_results();
                random_item();
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
